// ----- hdl/lsb_stego_embed_extract_assert.svh -----
// Assertion macros for the LSB stego embed/extract block.
`ifndef LSB_STEGO_EMBED_EXTRACT_ASSERT_SVH
`define LSB_STEGO_EMBED_EXTRACT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSBSE_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lsb_stego_embed_extract: assertion failed");

// Next-cycle implication, checked outside reset.
`define LSBSE_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lsb_stego_embed_extract: assertion failed");

`endif

// ----- hdl/lsbse_pkg.sv -----
// Package: payload types, codes and defaults of the LSB stego embed/extract block.
`timescale 1ns / 1ps

package lsbse_pkg;

   // Action codes
   localparam logic [1:0] ACT_PUSH    = 2'd0;
   localparam logic [1:0] ACT_EMBED   = 2'd1;
   localparam logic [1:0] ACT_PASS    = 2'd2;
   localparam logic [1:0] ACT_EXTRACT = 2'd3;

   // Result kinds
   localparam logic KIND_COVER   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // CSR indexes
   localparam logic [1:0] CSR_BITS_PER_BYTE  = 2'd0;
   localparam logic [1:0] CSR_EXTRACT_LENGTH = 2'd1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int RESERVOIR_BITS_DEF = 16;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0] value;
      logic       kind;
      logic       error;
      logic       done_res;
   } rsp_type;

endpackage

// ----- hdl/lsb_stego_embed_extract.sv -----
// Top level: LSB steganography embed/extract datapath with registered output.
//
// Usage
//  - req channel: one item per accepted req_valid/!req_stall edge. action selects
//    push (payload byte into the bit reservoir), embed (cover byte low N bits
//    replaced by the oldest reservoir bits), pass (cover byte unchanged) or
//    extract (low N cover bits packed MSB first into payload bytes).
//  - rsp channel: at most one item per request; push without overflow and
//    extract without a finished byte give none.
//  - csr port: bits_per_byte (index 0, clamped to 1..8) and extract_length
//    (index 1); write only while the block is idle.
//  - Results are registered into the output register (or the skid entry). Throughput:
//    one item per cycle while req_stall is low; all state updates are shift/mask logic.
//  - Stall: a two-entry output buffer (output register plus skid) lets one more
//    item in while a result waits; req_stall rises when the skid entry is full.
//  - Reset: synchronous, active high; empties both output entries and clears the
//    reservoir, assembly byte and recovered-byte counter; N returns to 1 and
//    extract_length to 0.
`timescale 1ns / 1ps

module lsb_stego_embed_extract #(
   parameter int RESERVOIR_BITS = lsbse_pkg::RESERVOIR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lsbse_pkg::req_type                  req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lsbse_pkg::rsp_type                  rsp_item,
   input  logic                                csr_write_en,
   input  logic [lsbse_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lsbse_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lsbse_pkg::*;

   `include "lsb_stego_embed_extract_assert.svh"

   localparam int CW = $clog2(RESERVOIR_BITS + 1);
   localparam logic [CW:0] RES_LIMIT = (CW + 1)'(RESERVOIR_BITS);

   // bit reverse of a byte
   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7 - i];
      end
      return r;
   endfunction

   // configuration
   logic [3:0]  bpb_ff;
   logic [31:0] xlen_ff;

   // state
   logic [RESERVOIR_BITS-1:0] res_ff, res_in;
   logic [CW-1:0]             rcnt_ff, rcnt_in;
   logic [7:0]                asm_ff, asm_in;
   logic [2:0]                acnt_ff, acnt_in;
   logic [31:0]               brec_ff, brec_in;

   // output buffer
   logic    main_valid_ff, main_valid_in;
   rsp_type main_ff, main_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   logic    accept, pop, produce;
   rsp_type result;

   // datapath temporaries
   logic [3:0]                n_eff;
   logic [7:0]                low_mask;
   logic [3:0]                take_k;
   logic [CW-1:0]             res_shamt;
   logic [RESERVOIR_BITS-1:0] res_window;
   logic [7:0]                emb_low;
   logic [15:0]               x_total;
   logic [4:0]                x_sum;
   logic [2:0]                x_rem;
   logic                      x_complete, x_active, x_done;
   logic [31:0]               brec_next;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_item  = main_ff;

   // N clamp: 0 acts as 1, 9..15 act as 8
   always_comb begin
      if (bpb_ff == 4'd0) begin
         n_eff = 4'd1;
      end else if (bpb_ff > 4'd8) begin
         n_eff = 4'd8;
      end else begin
         n_eff = bpb_ff;
      end
   end

   assign low_mask = 8'((9'd1 << n_eff) - 9'd1);

   // embed: oldest bit sits at rcnt-1, goes to cover bit 0
   always_comb begin
      if (rcnt_ff >= CW'(n_eff)) begin
         take_k = n_eff;
      end else begin
         take_k = 4'(rcnt_ff);
      end
      res_shamt  = rcnt_ff - CW'(take_k);
      res_window = res_ff >> res_shamt;
      emb_low    = rev8(res_window[7:0]) >> (4'd8 - take_k);
   end

   // extract: cover bit 0 enters the assembly first
   always_comb begin
      x_total    = (16'(asm_ff) << n_eff) | 16'(rev8(req_item.data) >> (4'd8 - n_eff));
      x_sum      = 5'(acnt_ff) + 5'(n_eff);
      x_complete = (x_sum >= 5'd8);
      x_rem      = 3'(x_sum - 5'd8);
      x_active   = (brec_ff < xlen_ff);
      brec_next  = brec_ff + 32'd1;
      x_done     = (brec_next >= xlen_ff);
   end

   // item processing
   always_comb begin
      res_in   = res_ff;
      rcnt_in  = rcnt_ff;
      asm_in   = asm_ff;
      acnt_in  = acnt_ff;
      brec_in  = brec_ff;
      produce  = 1'b0;
      result   = '{value: req_item.data, kind: KIND_COVER, error: 1'b0, done_res: 1'b0};
      if (accept) begin
         unique case (req_item.action)
            ACT_PUSH: begin
               if (({1'b0, rcnt_ff} + (CW + 1)'(8)) > RES_LIMIT) begin
                  produce      = 1'b1;
                  result.value = 8'd0;
                  result.error = 1'b1;
               end else begin
                  res_in  = {res_ff[RESERVOIR_BITS-9:0], req_item.data};
                  rcnt_in = rcnt_ff + CW'(8);
               end
            end
            ACT_EMBED: begin
               produce      = 1'b1;
               result.value = (req_item.data & ~low_mask) | emb_low;
               rcnt_in      = res_shamt;
            end
            ACT_PASS: begin
               produce = 1'b1;
            end
            ACT_EXTRACT: begin
               if (x_active) begin
                  if (x_complete) begin
                     produce         = 1'b1;
                     result.value    = 8'(x_total >> x_rem);
                     result.kind     = KIND_PAYLOAD;
                     result.done_res = x_done;
                     brec_in         = brec_next;
                     if (x_done) begin
                        asm_in  = 8'd0;
                        acnt_in = 3'd0;
                     end else begin
                        asm_in  = x_total[7:0] & 8'((9'd1 << x_rem) - 9'd1);
                        acnt_in = x_rem;
                     end
                  end else begin
                     asm_in  = x_total[7:0];
                     acnt_in = x_sum[2:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register plus skid entry
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = produce;
            main_in       = result;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpb_ff        <= 4'd1;
         xlen_ff       <= 32'd0;
         res_ff        <= '0;
         rcnt_ff       <= '0;
         asm_ff        <= 8'd0;
         acnt_ff       <= 3'd0;
         brec_ff       <= 32'd0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_BITS_PER_BYTE:  bpb_ff  <= csr_wdata[3:0];
               CSR_EXTRACT_LENGTH: xlen_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         res_ff        <= res_in;
         rcnt_ff       <= rcnt_in;
         asm_ff        <= asm_in;
         acnt_ff       <= acnt_in;
         brec_ff       <= brec_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // checks
   `LSBSE_ASSERT_IMP(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   `LSBSE_ASSERT_IMP(a_res_count_bound, clock, reset, 1'b1, ({1'b0, rcnt_ff} <= RES_LIMIT))
   `LSBSE_ASSERT_IMP(a_done_is_payload, clock, reset, rsp_valid && rsp_item.done_res,
                     rsp_item.kind == KIND_PAYLOAD && !rsp_item.error)
   `LSBSE_ASSERT_NXT(a_full_skid_stalls, clock, reset, skid_valid_ff && rsp_stall,
                     req_stall)

endmodule
